// ----- hw/rtl/scalar_kalman_angle_range_assert.svh -----
// ----------------------------------------------------------------------------
// scalar kalman angle/range assertion macros
// clocked on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef SCALAR_KALMAN_ANGLE_RANGE_ASSERT_SVH
`define SCALAR_KALMAN_ANGLE_RANGE_ASSERT_SVH

// condition holds on every clock edge
`define SKAR_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define SKAR_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define SKAR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/skar_pkg.sv -----
// ----------------------------------------------------------------------------
// skar_pkg
// widths, constants, types and sequencer states of the angle/range smoother
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package skar_pkg;

  // channels and word fields
  localparam int NUM_CHANNELS = 4;
  localparam int CH_W         = 2;
  localparam int ANG_W        = 9;
  localparam int RNG_W        = 16;
  localparam int NOISE_W      = 16;
  localparam int FRAC_W       = 8;

  // filter state widths
  localparam int AX_W   = ANG_W + FRAC_W;   // angle estimate, signed Q9.8
  localparam int RX_W   = RNG_W + FRAC_W;   // range estimate, Q16.8
  localparam int COV_W  = 16;               // covariance, Q4.12
  localparam int DIFF_W = RX_W + 1;         // innovation, signed
  localparam int MAG_W  = RX_W;             // innovation magnitude
  localparam int K_W    = 16;               // gain, Q0.16
  localparam int DEN_W  = COV_W + 1;        // p + r
  localparam int CNT_W  = 5;                // divider step counter

  // shared multiplier operands
  localparam int MA_W   = K_W + 1;
  localparam int MB_W   = MAG_W;
  localparam int PROD_W = MA_W + MB_W;

  // constants
  localparam logic [COV_W-1:0]  COV_ONE     = 16'd4096;
  localparam logic [MA_W-1:0]   K_ONE       = 17'h10000;
  localparam logic [PROD_W-1:0] PROD_HALF   = 41'd32768;
  localparam logic [7:0]        ANGLE_LIMIT = 8'd180;
  localparam logic [CNT_W-1:0]  DIV_STEPS   = 5'(K_W);

  // register reset values
  localparam logic [NOISE_W-1:0] ANGLE_Q_RST = 16'd1638;
  localparam logic [NOISE_W-1:0] ANGLE_R_RST = 16'd2867;
  localparam logic [NOISE_W-1:0] RANGE_Q_RST = 16'd1229;
  localparam logic [NOISE_W-1:0] RANGE_R_RST = 16'd2048;

  // register indexes
  typedef enum logic [1:0] {
    REG_ANGLE_Q = 2'd0,
    REG_ANGLE_R = 2'd1,
    REG_RANGE_Q = 2'd2,
    REG_RANGE_R = 2'd3
  } reg_idx_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_PRED,
    S_DIVS,
    S_DIV,
    S_MUL1,
    S_MUL2,
    S_MUL3,
    S_RES
  } state_t;

  // divider request and response
  typedef struct packed {
    logic             start;
    logic [K_W-1:0]   num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic           done;
    logic           busy;
    logic [K_W-1:0] k;
  } div_rsp_t;

endpackage

// ----- hw/rtl/scalar_kalman_angle_range.sv -----
// ----------------------------------------------------------------------------
// scalar_kalman_angle_range
// per-channel scalar kalman smoothing of an angle and a range sample
// ----------------------------------------------------------------------------
//  channel | handshake          | payload
//  --------+--------------------+---------------------------------------------
//  in      | in_valid/in_ready  | in_channel, in_meas_angle, in_meas_range
//  out     | out_valid/out_ready| out_channel, out_filtered_angle,
//          |                    | out_filtered_range
//  cfg     | apb psel/penable   | paddr, pwdata, prdata (q and r registers)
//
//  a primed channel runs two filter passes per word, angle then range (predict,
//  divider start, 16 divider steps plus done, two multiplies and a covariance
//  write), paced by the shared one-bit-a-cycle divider
//  a pass whose r is zero or whose p + r is zero skips the divider steps
//  a first word on a channel or a word for an unknown channel skips the filter
//  reset clears the primed flags and the noise registers to their defaults
//  in_ready is low while a word is worked on; a result waits in the output
//  register, and the block stalls before its next result until it is taken
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "scalar_kalman_angle_range_assert.svh"

module scalar_kalman_angle_range (
  input  logic                        clk,
  input  logic                        rst_n,
  // input words
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [skar_pkg::CH_W-1:0]   in_channel,
  input  logic [skar_pkg::ANG_W-1:0]  in_meas_angle,
  input  logic [skar_pkg::RNG_W-1:0]  in_meas_range,
  // result words
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [skar_pkg::CH_W-1:0]   out_channel,
  output logic [skar_pkg::ANG_W-1:0]  out_filtered_angle,
  output logic [skar_pkg::RNG_W-1:0]  out_filtered_range,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [3:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import skar_pkg::*;

  // configuration registers
  logic [NOISE_W-1:0] angle_q_r, angle_r_r, range_q_r, range_r_r;

  // channel state
  logic [NUM_CHANNELS-1:0] primed_r;
  logic [AX_W-1:0]         ang_est_r [NUM_CHANNELS];
  logic [COV_W-1:0]        ang_cov_r [NUM_CHANNELS];
  logic [RX_W-1:0]         rng_est_r [NUM_CHANNELS];
  logic [COV_W-1:0]        rng_cov_r [NUM_CHANNELS];

  // sequencer and working registers
  state_t             state_r, state_nxt;
  logic               filt_r;
  logic               ch_ok_r;
  logic [CH_W-1:0]    ch_r;
  logic [ANG_W-1:0]   ang_r;
  logic [RNG_W-1:0]   rng_r;
  logic [COV_W-1:0]   pp_r;
  logic [DIFF_W-1:0]  diff_r;
  logic [K_W-1:0]     k_r;

  // output register
  logic               out_valid_r;
  logic [CH_W-1:0]    out_ch_r;
  logic [ANG_W-1:0]   out_ang_r;
  logic [RNG_W-1:0]   out_rng_r;

  // datapath signals
  logic               accept;
  logic               in_ch_ok;
  logic               out_load;
  logic               cfg_wr;
  reg_idx_t           cfg_idx;
  div_req_t           div_req;
  div_rsp_t           div_rsp;
  logic [MA_W-1:0]    mul_a;
  logic [MB_W-1:0]    mul_b;
  logic [PROD_W-1:0]  prod;
  logic [DIFF_W-1:0]  cur_x;
  logic [DIFF_W-1:0]  meas8;
  logic [COV_W-1:0]   cur_p;
  logic [NOISE_W-1:0] cur_q;
  logic [NOISE_W-1:0] cur_r;
  logic [COV_W:0]     psum;
  logic               diff_neg;
  logic [DIFF_W-1:0]  diff_abs;
  logic [PROD_W-1:0]  prod_rnd;
  logic [DIFF_W-1:0]  rnd;
  logic [DIFF_W:0]    delta;
  logic [DIFF_W:0]    new_x;
  logic [COV_W-1:0]   new_p;
  logic [AX_W-1:0]    res_ax;
  logic               res_neg;
  logic [AX_W-1:0]    res_mag;
  logic [AX_W:0]      res_asum;
  logic [9:0]         res_around;
  logic [7:0]         res_asat;
  logic [ANG_W-1:0]   res_ang;
  logic [RX_W:0]      res_rsum;
  logic [RNG_W-1:0]   res_rng;

  // apb port
  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    unique case (cfg_idx)
      REG_ANGLE_Q: prdata = 32'(angle_q_r);
      REG_ANGLE_R: prdata = 32'(angle_r_r);
      REG_RANGE_Q: prdata = 32'(range_q_r);
      REG_RANGE_R: prdata = 32'(range_r_r);
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_q_r <= ANGLE_Q_RST;
      angle_r_r <= ANGLE_R_RST;
      range_q_r <= RANGE_Q_RST;
      range_r_r <= RANGE_R_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_ANGLE_Q: angle_q_r <= pwdata[NOISE_W-1:0];
        REG_ANGLE_R: angle_r_r <= pwdata[NOISE_W-1:0];
        REG_RANGE_Q: range_q_r <= pwdata[NOISE_W-1:0];
        REG_RANGE_R: range_r_r <= pwdata[NOISE_W-1:0];
        default: ;
      endcase
    end
  end

  // shared units
  skar_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  skar_mul u_mul (
    .clk   (clk),
    .mul_a (mul_a),
    .mul_b (mul_b),
    .prod  (prod)
  );

  // handshake terms
  assign accept   = in_valid && in_ready;
  assign in_ch_ok = (32'(in_channel) < NUM_CHANNELS);
  assign out_load = (state_r == S_RES) && (!out_valid_r || out_ready);

  // operands of the filter in progress
  always_comb begin
    if (filt_r) begin
      cur_x = {1'b0, rng_est_r[ch_r]};
      cur_p = rng_cov_r[ch_r];
      cur_q = range_q_r;
      cur_r = range_r_r;
      meas8 = {1'b0, rng_r, {FRAC_W{1'b0}}};
    end else begin
      cur_x = {{(DIFF_W-AX_W){ang_est_r[ch_r][AX_W-1]}}, ang_est_r[ch_r]};
      cur_p = ang_cov_r[ch_r];
      cur_q = angle_q_r;
      cur_r = angle_r_r;
      meas8 = {{(DIFF_W-AX_W){ang_r[ANG_W-1]}}, ang_r, {FRAC_W{1'b0}}};
    end
  end

  // prediction sum
  assign psum = {1'b0, cur_p} + {1'b0, cur_q};

  // innovation magnitude for the correction multiply
  assign diff_neg = diff_r[DIFF_W-1];
  assign diff_abs = diff_neg ? (DIFF_W'(0) - diff_r) : diff_r;

  // correction rounded half away from zero, and new covariance
  assign prod_rnd = prod + PROD_HALF;
  assign rnd      = prod_rnd[PROD_W-1:K_W];
  assign delta    = diff_neg ? ((DIFF_W+1)'(0) - {1'b0, rnd}) : {1'b0, rnd};
  assign new_x    = {cur_x[DIFF_W-1], cur_x} + delta;
  assign new_p    = prod_rnd[K_W+COV_W-1:K_W];

  // result rounding and saturation
  assign res_ax     = ang_est_r[ch_r];
  assign res_neg    = res_ax[AX_W-1];
  assign res_mag    = res_neg ? (AX_W'(0) - res_ax) : res_ax;
  assign res_asum   = {1'b0, res_mag} + (AX_W+1)'(128);
  assign res_around = res_asum[AX_W:FRAC_W];
  assign res_asat   = (res_around > 10'(ANGLE_LIMIT)) ? ANGLE_LIMIT : res_around[7:0];
  assign res_ang    = res_neg ? (ANG_W'(0) - {1'b0, res_asat}) : {1'b0, res_asat};
  assign res_rsum   = {1'b0, rng_est_r[ch_r]} + (RX_W+1)'(128);
  assign res_rng    = res_rsum[RX_W] ? '1 : res_rsum[RX_W-1:FRAC_W];

  // sequencer state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state, divider request and multiplier operands
  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    div_req   = '0;
    mul_a     = {1'b0, k_r};
    mul_b     = diff_abs[MB_W-1:0];
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_ch_ok && primed_r[in_channel]) begin
            state_nxt = S_PRED;
          end else begin
            state_nxt = S_RES;
          end
        end
      end
      S_PRED: state_nxt = S_DIVS;
      S_DIVS: begin
        div_req.start = 1'b1;
        div_req.num   = pp_r;
        div_req.den   = {1'b0, pp_r} + {1'b0, cur_r};
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        if (div_rsp.done) begin
          state_nxt = S_MUL1;
        end
      end
      S_MUL1: state_nxt = S_MUL2;
      S_MUL2: begin
        mul_a     = K_ONE - {1'b0, k_r};
        mul_b     = MB_W'(pp_r);
        state_nxt = S_MUL3;
      end
      S_MUL3: state_nxt = filt_r ? S_RES : S_PRED;
      S_RES: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers of the word in progress
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filt_r   <= 1'b0;
      ch_ok_r  <= 1'b0;
      primed_r <= '0;
    end else begin
      if (accept) begin
        filt_r  <= 1'b0;
        ch_ok_r <= in_ch_ok;
        if (in_ch_ok) begin
          primed_r[in_channel] <= 1'b1;
        end
      end else if (state_r == S_MUL3) begin
        filt_r <= 1'b1;
      end
    end
  end

  // working registers and channel state
  always_ff @(posedge clk) begin
    if (accept) begin
      ch_r  <= in_channel;
      ang_r <= in_meas_angle;
      rng_r <= in_meas_range;
      // first word on a channel loads the estimates
      if (in_ch_ok && !primed_r[in_channel]) begin
        ang_est_r[in_channel] <= {in_meas_angle, {FRAC_W{1'b0}}};
        ang_cov_r[in_channel] <= COV_ONE;
        rng_est_r[in_channel] <= {in_meas_range, {FRAC_W{1'b0}}};
        rng_cov_r[in_channel] <= COV_ONE;
      end
    end
    unique case (state_r)
      S_PRED: begin
        pp_r   <= psum[COV_W] ? '1 : psum[COV_W-1:0];
        diff_r <= meas8 - cur_x;
      end
      S_DIV: begin
        if (div_rsp.done) begin
          k_r <= div_rsp.k;
        end
      end
      S_MUL2: begin
        if (filt_r) begin
          rng_est_r[ch_r] <= new_x[RX_W-1:0];
        end else begin
          ang_est_r[ch_r] <= new_x[AX_W-1:0];
        end
      end
      S_MUL3: begin
        if (filt_r) begin
          rng_cov_r[ch_r] <= new_p;
        end else begin
          ang_cov_r[ch_r] <= new_p;
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ch_r  <= ch_r;
      out_ang_r <= ch_ok_r ? res_ang : '0;
      out_rng_r <= ch_ok_r ? res_rng : '0;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_channel        = out_ch_r;
  assign out_filtered_angle = out_ang_r;
  assign out_filtered_range = out_rng_r;

  // checks
  `SKAR_ASSERT_NEXT(a_busy_after_accept, accept, !in_ready, "ready after accepted word")
  `SKAR_ASSERT_NEXT(a_div_to_mul, (state_r == S_DIV) && div_rsp.done, state_r == S_MUL1,
                    "divider done not followed by multiply")
  `SKAR_ASSERT_NEXT(a_hold_result, (state_r == S_RES) && out_valid_r && !out_ready,
                    state_r == S_RES, "result left while output register full")
  `SKAR_ASSERT_IMPL(a_div_owned, div_rsp.busy, state_r == S_DIV,
                    "divider busy outside divide state")

endmodule

// ----- hw/rtl/skar_div.sv -----
// ----------------------------------------------------------------------------
// skar_div
// restoring divider for the gain k = floor(p * 2^16 / (p + r)), one bit a cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module skar_div (
  input  logic               clk,
  input  logic               rst_n,
  input  skar_pkg::div_req_t req,
  output skar_pkg::div_rsp_t rsp
);
  import skar_pkg::*;

  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [K_W-1:0]   quot_r;
  logic [CNT_W-1:0] cnt_r;
  logic             done_r;
  logic [DEN_W:0]   shift;
  logic             fits;
  logic             den_zero;
  logic             gain_full;

  // special cases: zero denominator gives 0, r of zero gives the top gain
  assign den_zero  = (req.den == '0);
  assign gain_full = ({1'b0, req.num} >= req.den);

  // one quotient bit per step
  assign shift = {rem_r, 1'b0};
  assign fits  = (shift >= {1'b0, den_r});

  // step counter and done pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        if (den_zero || gain_full) begin
          done_r <= 1'b1;
        end else begin
          cnt_r <= DIV_STEPS;
        end
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  // remainder and quotient
  always_ff @(posedge clk) begin
    if (req.start) begin
      den_r <= req.den;
      rem_r <= {1'b0, req.num};
      if (den_zero) begin
        quot_r <= '0;
      end else if (gain_full) begin
        quot_r <= '1;
      end else begin
        quot_r <= '0;
      end
    end else if (cnt_r != '0) begin
      if (fits) begin
        rem_r  <= DEN_W'(shift - {1'b0, den_r});
        quot_r <= {quot_r[K_W-2:0], 1'b1};
      end else begin
        rem_r  <= shift[DEN_W-1:0];
        quot_r <= {quot_r[K_W-2:0], 1'b0};
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.busy = (cnt_r != '0);
  assign rsp.k    = quot_r;

endmodule

// ----- hw/rtl/skar_mul.sv -----
// ----------------------------------------------------------------------------
// skar_mul
// shared unsigned multiplier with registered product
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module skar_mul (
  input  logic                        clk,
  input  logic [skar_pkg::MA_W-1:0]   mul_a,
  input  logic [skar_pkg::MB_W-1:0]   mul_b,
  output logic [skar_pkg::PROD_W-1:0] prod
);
  import skar_pkg::*;

  logic [PROD_W-1:0] prod_r;

  // product is ready the cycle after the operands
  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  assign prod = prod_r;

endmodule

// ----- sim/tb_scalar_kalman_angle_range.sv -----
// ----------------------------------------------------------------------------
// tb_scalar_kalman_angle_range
// self-checking bench for the per-channel angle/range kalman smoother: a
// clocked driver feeds words from a queue, a bit-exact filter predictor runs
// on every accepted word, and a clocked monitor checks each result word;
// the noise registers are reprogrammed over apb between idle phases
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_scalar_kalman_angle_range;
  import skar_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 300;
  localparam int IDLE_WAIT   = 60;

  typedef struct {
    logic [CH_W-1:0]  ch;
    logic [ANG_W-1:0] angle;
    logic [RNG_W-1:0] rng;
  } meas_word_t;

  typedef struct {
    logic [CH_W-1:0]  ch;
    logic [ANG_W-1:0] angle;
    logic [RNG_W-1:0] rng;
  } smooth_word_t;

  // clock, reset and dut ports
  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [CH_W-1:0]   in_channel = '0;
  logic [ANG_W-1:0]  in_meas_angle = '0;
  logic [RNG_W-1:0]  in_meas_range = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [CH_W-1:0]   out_channel;
  logic [ANG_W-1:0]  out_filtered_angle;
  logic [RNG_W-1:0]  out_filtered_range;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [3:0]        paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  // bench state
  meas_word_t   meas_queue[$];
  smooth_word_t smoothed_queue[$];
  int           mismatches = 0;
  int           in_gap = 0;
  int           out_gap = 0;
  int           hold_left = 0;
  int           hold_mark = -1;
  int           in_acc_count = 0;
  int           cycle_cnt = 0;
  bit           in_steady = 1'b0;
  bit           out_steady = 1'b0;

  // predictor copy of registers and filter state (index 0 angle, 1 range)
  logic [NOISE_W-1:0] cfg_val [4];
  bit                 ch_primed [NUM_CHANNELS];
  longint             est_q8 [2][NUM_CHANNELS];
  longint             cov_q12 [2][NUM_CHANNELS];

  // stimulus tracks for well-formed measurement sequences
  int trk_ang [NUM_CHANNELS];
  int trk_rng [NUM_CHANNELS];

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  scalar_kalman_angle_range DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_channel         (in_channel),
    .in_meas_angle      (in_meas_angle),
    .in_meas_range      (in_meas_range),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_channel        (out_channel),
    .out_filtered_angle (out_filtered_angle),
    .out_filtered_range (out_filtered_range),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  // error bookkeeping, only the first 10 get printed
  task automatic flag_error(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", msg);
  endtask

  // one scalar filter update on filter f of channel c
  function automatic void filter_update(input int f, input int c, input longint meas8);
    longint q, r, pp, den, k, diff, prod, mag, rnd;
    q = (f == 0) ? longint'(cfg_val[REG_ANGLE_Q]) : longint'(cfg_val[REG_RANGE_Q]);
    r = (f == 0) ? longint'(cfg_val[REG_ANGLE_R]) : longint'(cfg_val[REG_RANGE_R]);
    pp = cov_q12[f][c] + q;
    if (pp > 65535) pp = 65535;
    den = pp + r;
    if (den == 0) begin
      k = 0;
    end else begin
      k = (pp * 65536) / den;
      if (k > 65535) k = 65535;
    end
    diff = meas8 - est_q8[f][c];
    prod = k * diff;
    mag = (prod < 0) ? -prod : prod;
    rnd = (mag + 32768) / 65536;
    est_q8[f][c] = est_q8[f][c] + ((prod < 0) ? -rnd : rnd);
    cov_q12[f][c] = ((pp * (65536 - k) + 32768) / 65536) % 65536;
  endfunction

  // 8 fraction bits to integer, half away from zero
  function automatic longint round_q8(input longint x);
    longint mag, r;
    mag = (x < 0) ? -x : x;
    r = (mag + 128) / 256;
    return (x < 0) ? -r : r;
  endfunction

  // expected result word for one accepted measurement word
  function automatic smooth_word_t smooth_predict(input meas_word_t w);
    int           c;
    longint       a, rg, fa, fr;
    smooth_word_t res;
    c = int'(w.ch);
    a = longint'($signed(w.angle));
    rg = longint'(w.rng);
    fa = 0;
    fr = 0;
    if (c < NUM_CHANNELS) begin
      if (!ch_primed[c]) begin
        ch_primed[c] = 1'b1;
        est_q8[0][c] = a * 256;
        est_q8[1][c] = rg * 256;
        cov_q12[0][c] = 4096;
        cov_q12[1][c] = 4096;
      end else begin
        filter_update(0, c, a * 256);
        filter_update(1, c, rg * 256);
      end
      fa = round_q8(est_q8[0][c]);
      if (fa > 180) fa = 180;
      if (fa < -180) fa = -180;
      fr = round_q8(est_q8[1][c]);
      if (fr > 65535) fr = 65535;
      if (fr < 0) fr = 0;
    end
    res.ch = w.ch;
    res.angle = fa[ANG_W-1:0];
    res.rng = fr[RNG_W-1:0];
    return res;
  endfunction

  // idle length: mostly none or short, a few long
  function automatic int pick_gap(input bit steady);
    int roll;
    roll = $urandom_range(99);
    if (steady || roll < 55) return 0;
    if (roll < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // noise value with weight on the extremes
  function automatic logic [NOISE_W-1:0] pick_noise();
    int roll;
    roll = $urandom_range(99);
    if (roll < 10) return '0;
    if (roll < 20) return '1;
    if (roll < 30) return 16'd1;
    if (roll < 70) return 16'($urandom_range(8191, 1));
    return 16'($urandom_range(65535));
  endfunction

  // input driver
  always @(posedge clk) begin : drive_proc
    meas_word_t nxt;
    meas_word_t cur;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap <= 0;
    end else begin
      if (in_valid && in_ready) begin
        cur.ch = in_channel;
        cur.angle = in_meas_angle;
        cur.rng = in_meas_range;
        smoothed_queue.push_back(smooth_predict(cur));
        in_acc_count <= in_acc_count + 1;
      end
      if (in_valid && !in_ready) begin
        // hold the word until it is taken
      end else if (in_gap != 0) begin
        in_valid <= 1'b0;
        in_gap <= in_gap - 1;
      end else if (meas_queue.size() != 0) begin
        nxt = meas_queue.pop_front();
        in_channel <= nxt.ch;
        in_meas_angle <= nxt.angle;
        in_meas_range <= nxt.rng;
        in_valid <= 1'b1;
        in_gap <= pick_gap(in_steady);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // long receiver hold-off, started at fixed points of the input count
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (in_acc_count % 350 == 100 && in_acc_count != hold_mark) begin
      hold_left <= HOLD_CYCLES;
      hold_mark <= in_acc_count;
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk) begin : mon_proc
    smooth_word_t want;
    int           g;
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_gap <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (smoothed_queue.size() == 0) begin
          flag_error($sformatf("result word with nothing expected: ch %0d angle %0d range %0d",
                               out_channel, $signed(out_filtered_angle), out_filtered_range));
        end else begin
          want = smoothed_queue.pop_front();
          if (out_channel !== want.ch || out_filtered_angle !== want.angle ||
              out_filtered_range !== want.rng) begin
            flag_error($sformatf({"exp ch %0d angle %0d range %0d, ",
                                  "got ch %0d angle %0d range %0d"},
                                 want.ch, $signed(want.angle), want.rng, out_channel,
                                 $signed(out_filtered_angle), out_filtered_range));
          end
        end
      end
      if (hold_left != 0) begin
        out_ready <= 1'b0;
      end else if (out_valid && out_ready) begin
        g = pick_gap(out_steady);
        out_gap <= g;
        out_ready <= (g == 0);
      end else if (out_gap != 0) begin
        out_ready <= 1'b0;
        out_gap <= out_gap - 1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("tb_scalar_kalman_angle_range: FAIL");
      $finish;
    end
  end

  // register read-back
  task automatic cfg_check(input reg_idx_t idx);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    if (prdata !== {16'h0, cfg_val[idx]})
      flag_error($sformatf("register %0d read %0h, exp %0h", idx, prdata, cfg_val[idx]));
  endtask

  // register write, then read it back
  task automatic cfg_set(input reg_idx_t idx, input logic [NOISE_W-1:0] v);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {16'h0, v};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    cfg_val[idx] = v;
    cfg_check(idx);
  endtask

  task automatic set_all_noise(input logic [NOISE_W-1:0] q, input logic [NOISE_W-1:0] r);
    cfg_set(REG_ANGLE_Q, q);
    cfg_set(REG_ANGLE_R, r);
    cfg_set(REG_RANGE_Q, q);
    cfg_set(REG_RANGE_R, r);
  endtask

  task automatic queue_word(input int ch, input int ang, input int rng);
    meas_word_t w;
    w.ch = CH_W'(ch);
    w.angle = ANG_W'(ang);
    w.rng = RNG_W'(rng);
    meas_queue.push_back(w);
  endtask

  // wait until every word is in and every result is out, then let it settle
  task automatic wait_idle();
    do @(negedge clk);
    while (meas_queue.size() != 0 || in_valid || smoothed_queue.size() != 0);
    repeat (IDLE_WAIT) @(negedge clk);
  endtask

  // random words: mostly noisy tracks per channel, the rest raw noise
  task automatic fill_random(input int n);
    int ch, roll, ang, rng;
    for (int i = 0; i < n; i++) begin
      ch = $urandom_range(NUM_CHANNELS - 1);
      roll = $urandom_range(99);
      if (roll < 70) begin
        trk_ang[ch] += int'($urandom_range(6)) - 3;
        if (trk_ang[ch] > 200) trk_ang[ch] = 200;
        if (trk_ang[ch] < -200) trk_ang[ch] = -200;
        trk_rng[ch] += int'($urandom_range(100)) - 50;
        if (trk_rng[ch] > 65535) trk_rng[ch] = 65535;
        if (trk_rng[ch] < 0) trk_rng[ch] = 0;
        ang = trk_ang[ch] + int'($urandom_range(16)) - 8;
        rng = trk_rng[ch] + int'($urandom_range(200)) - 100;
        if (rng > 65535) rng = 65535;
        if (rng < 0) rng = 0;
      end else if (roll < 85) begin
        ang = int'($urandom_range(360)) - 180;
        rng = $urandom_range(65535);
      end else begin
        ang = $urandom_range(511);
        rng = $urandom_range(65535);
        if (roll >= 97) trk_rng[ch] = ($urandom_range(1) != 0) ? 65535 : 0;
      end
      queue_word(ch, ang, rng);
    end
  endtask

  // main sequence
  initial begin
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    rst_n = 1'b0;
    cfg_val[REG_ANGLE_Q] = ANGLE_Q_RST;
    cfg_val[REG_ANGLE_R] = ANGLE_R_RST;
    cfg_val[REG_RANGE_Q] = RANGE_Q_RST;
    cfg_val[REG_RANGE_R] = RANGE_R_RST;
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      ch_primed[c] = 1'b0;
      est_q8[0][c] = 0;
      est_q8[1][c] = 0;
      cov_q12[0][c] = 0;
      cov_q12[1][c] = 0;
      trk_ang[c] = 0;
      trk_rng[c] = 30000;
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // reset values of the noise registers
    cfg_check(REG_ANGLE_Q);
    cfg_check(REG_ANGLE_R);
    cfg_check(REG_RANGE_Q);
    cfg_check(REG_RANGE_R);

    // default noise: first words on each channel, then field extremes
    queue_word(0, 0, 0);
    queue_word(1, 255, 65535);
    queue_word(2, -256, 0);
    queue_word(3, 180, 12345);
    queue_word(0, 255, 65535);
    queue_word(1, -256, 0);
    queue_word(2, 255, 65535);
    queue_word(3, -180, 0);
    queue_word(0, -1, 1);
    queue_word(0, 1, 65534);
    wait_idle();

    // zero process and measurement noise, then covariance at zero gives a zero denominator
    set_all_noise(16'd0, 16'd0);
    queue_word(0, 100, 500);
    queue_word(0, -100, 40000);
    queue_word(0, 50, 7);
    queue_word(1, 0, 0);
    queue_word(1, 0, 0);
    wait_idle();

    // largest noise, prediction saturates
    set_all_noise(16'hFFFF, 16'hFFFF);
    queue_word(2, -256, 65535);
    queue_word(2, 255, 0);
    queue_word(2, -180, 65535);
    queue_word(3, 255, 65535);
    queue_word(3, -256, 0);
    wait_idle();

    // large process noise, smallest nonzero measurement noise
    set_all_noise(16'hFFFF, 16'd1);
    queue_word(1, 180, 65535);
    queue_word(1, -180, 1);
    wait_idle();

    // random phases with random noise settings and idling
    for (int ph = 0; ph < 7; ph++) begin
      cfg_set(REG_ANGLE_Q, pick_noise());
      cfg_set(REG_ANGLE_R, pick_noise());
      cfg_set(REG_RANGE_Q, pick_noise());
      cfg_set(REG_RANGE_R, pick_noise());
      in_steady = ($urandom_range(3) == 0);
      out_steady = ($urandom_range(3) == 0);
      fill_random(200);
      wait_idle();
    end

    if (mismatches == 0 && smoothed_queue.size() == 0) begin
      $display("tb_scalar_kalman_angle_range: PASS");
    end else begin
      $display("tb_scalar_kalman_angle_range: FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/skar_pkg.sv
hw/rtl/skar_div.sv
hw/rtl/skar_mul.sv
hw/rtl/scalar_kalman_angle_range.sv
sim/tb_scalar_kalman_angle_range.sv
